// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When ante holds, cons must hold in the same cycle.
`define BDQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bdq_pkg.sv =====
// Types, codes and defaults for the bounded double-ended queue.
package bdq_pkg;

  localparam int CAPACITY_DEF = 16;

  // Internal command queue between front and back.
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_CW    = 2;

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_DUMP       = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] word;
    logic [1:0]         status;
    logic [4:0]         occupancy;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DUMP
  } op_t;

  // Head of the command queue as seen by the back end.
  typedef struct packed {
    logic               valid;
    op_t                op;
    logic signed [31:0] value;
  } cmd_head_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_POP,
    BK_DUMP
  } back_state_t;

endpackage

// ===== rtl/bdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bdq_front.sv =====
// Front end: accepts requests, decodes the action, queues commands.
`include "assert_macros.svh"

module bdq_front
  import bdq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output cmd_head_t head,
  input  logic      head_take
);

  cmd_t                 q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CW-1:0]   cnt_r, cnt_nxt;
  logic                 acc;
  logic                 known;
  logic                 enq;
  logic                 deq;
  op_t                  op_dec;

  // Action decode; unknown codes are accepted and dropped.
  always_comb begin
    known  = 1'b1;
    op_dec = OP_PUSH_FRONT;
    unique case (in_item.action)
      ACT_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      ACT_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      ACT_POP_FRONT:  op_dec = OP_POP_FRONT;
      ACT_POP_BACK:   op_dec = OP_POP_BACK;
      ACT_DUMP:       op_dec = OP_DUMP;
      default:        known  = 1'b0;
    endcase
  end

  assign in_full = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign acc     = in_push && !in_full;
  assign enq     = acc && known;
  assign deq     = head_take && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = enq ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = deq ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CMDQ_CW'(enq) - CMDQ_CW'(deq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      q_r[wr_ptr_r] <= '{op: op_dec, value: in_item.value};
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.op    = q_r[rd_ptr_r].op;
  assign head.value = q_r[rd_ptr_r].value;

  `BDQ_ASSERT(a_cmdq_bound, cnt_r <= CMDQ_CW'(CMDQ_DEPTH), "command queue overfilled")
  `BDQ_ASSERT_IMPL(a_take_valid, head_take, cnt_r != '0, "take from empty command queue")

endmodule

// ===== rtl/bdq_back.sv =====
// Back end: ring store, command execution and result register.
`include "assert_macros.svh"

module bdq_back
  import bdq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_head_t head,
  output logic      head_take,
  output logic      out_valid,
  output out_item_t out_item,
  input  logic      out_take
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W:0]   SUM_CAP  = (CNT_W + 1)'(CAPACITY);

  back_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r;
  out_item_t        res;
  logic             load;
  logic             out_free;
  logic             q_empty;
  logic             q_full;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [31:0]      ram_rdata;

  function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] dec_idx(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  // front + offset, both below CAPACITY-ish, so one subtract wraps it
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [IDX_W-1:0] f,
                                                input logic [CNT_W-1:0] n);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(f) + (CNT_W + 1)'(n);
    if (s >= SUM_CAP) begin
      s = s - SUM_CAP;
    end
    return s[IDX_W-1:0];
  endfunction

  assign q_empty  = (count_r == '0);
  assign q_full   = (count_r == FULL_CNT);
  assign out_free = !out_valid_r || out_take;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (head.valid && !q_empty) begin
          if (head.op == OP_POP_FRONT || head.op == OP_POP_BACK) begin
            state_nxt = BK_POP;
          end else if (head.op == OP_DUMP) begin
            state_nxt = BK_DUMP;
          end
        end
      end
      BK_POP: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_DUMP: begin
        if (out_free && rem_r == CNT_W'(1)) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    head_take = 1'b0;
    load      = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = front_r;
    ram_re    = 1'b0;
    ram_raddr = front_r;
    front_nxt = front_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    rem_nxt   = rem_r;
    res       = '{word: '0, status: STAT_OK, occupancy: 5'(count_r), last: 1'b1};
    unique case (state_r)
      BK_IDLE: begin
        if (head.valid) begin
          unique case (head.op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (out_free) begin
                load      = 1'b1;
                head_take = 1'b1;
                if (q_full) begin
                  res.status = STAT_FULL;
                end else begin
                  ram_we = 1'b1;
                  if (head.op == OP_PUSH_FRONT) begin
                    front_nxt = dec_idx(front_r);
                    ram_waddr = dec_idx(front_r);
                  end else begin
                    ram_waddr = wrap_idx(front_r, count_r);
                  end
                  count_nxt     = count_r + 1'b1;
                  res.occupancy = 5'(count_r + 1'b1);
                end
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_DUMP: begin
              if (q_empty) begin
                if (out_free) begin
                  load       = 1'b1;
                  head_take  = 1'b1;
                  res.status = STAT_EMPTY;
                end
              end else begin
                ram_re = 1'b1;
                if (head.op == OP_POP_FRONT) begin
                  ram_raddr = front_r;
                  front_nxt = inc_idx(front_r);
                  count_nxt = count_r - 1'b1;
                end else if (head.op == OP_POP_BACK) begin
                  ram_raddr = wrap_idx(front_r, count_r - 1'b1);
                  count_nxt = count_r - 1'b1;
                end else begin
                  ram_raddr = front_r;
                  ptr_nxt   = inc_idx(front_r);
                  rem_nxt   = count_r;
                end
              end
            end
            default: ;
          endcase
        end
      end
      BK_POP: begin
        if (out_free) begin
          load      = 1'b1;
          head_take = 1'b1;
          res.word  = ram_rdata;
        end
      end
      BK_DUMP: begin
        if (out_free) begin
          load     = 1'b1;
          res.word = ram_rdata;
          res.last = (rem_r == CNT_W'(1));
          if (rem_r == CNT_W'(1)) begin
            head_take = 1'b1;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_r;
            ptr_nxt   = inc_idx(ptr_r);
            rem_nxt   = rem_r - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      ptr_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
      ptr_r   <= ptr_nxt;
      rem_r   <= rem_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r <= res;
    end
  end

  bdq_ram #(
    .WIDTH(32),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (head.value),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `BDQ_ASSERT(a_count_bound, count_r <= FULL_CNT, "count above capacity")
  `BDQ_ASSERT_IMPL(a_dump_rem, state_r == BK_DUMP, rem_r != '0 && rem_r <= count_r,
                   "dump walk out of range")
  `BDQ_ASSERT_IMPL(a_no_overwrite, load, out_free, "result register overwritten")

endmodule

// ===== rtl/bounded_double_ended_queue_top.sv =====
// Top level of the bounded double-ended queue.
//
// Input channel (queue style): drive in_item and raise in_push; a request is
// taken at a clock edge where in_push is high and in_full is low. Actions:
// push front, push back, pop front, pop back, dump. Undefined action codes
// are taken and dropped without a result.
// Result channel (queue style): while out_empty is low, out_item holds the
// oldest result; it is taken at an edge where out_pop is high.
// A push result, or the error result of a pop or dump on an empty deque,
// passes through the command queue and the result register; a pop result and
// the first word of a dump also pass through the registered slot RAM read.
// Push and error requests complete in the idle state; a pop also passes the
// POP state, for the registered read of the slot RAM; a dump gives one stored
// word per cycle while results are taken. Both hold the back end until done.
// A two-entry command queue separates request decode from execution, so new
// requests keep arriving while the back end waits on a stalled receiver; when
// results are not popped the result register holds and the command queue fills,
// which raises in_full.
// Reset (rst_n low, synchronous) empties the deque, the command queue and the
// result register; slot contents are not cleared and are never read unwritten.
`include "assert_macros.svh"

module bounded_double_ended_queue_top
  import bdq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);

  cmd_head_t head;
  logic      head_take;
  logic      out_valid;
  logic      out_take;

  // Result is taken only when one is actually waiting.
  assign out_take  = out_pop && out_valid;
  assign out_empty = !out_valid;

  bdq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .head      (head),
    .head_take (head_take)
  );

  bdq_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_take (head_take),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_take  (out_take)
  );

  // Every result carries a legal status code.
  `BDQ_ASSERT_IMPL(a_status_code, !out_empty,
                   out_item.status == STAT_OK || out_item.status == STAT_EMPTY ||
                   out_item.status == STAT_FULL, "illegal status on result")

endmodule
